// ===== rtl/uer_pkg.sv =====
// Shared types, register codes and reset values for the ultrasonic echo ranger.
package uer_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int DIST_W          = 24;
	localparam int TIMEOUT_W       = 16;
	localparam int TRIG_W          = 8;
	localparam int SCALE_W         = 16;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAR     = 2'd3;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd3000;
	localparam logic [TRIG_W-1:0]    TRIGGER_RST = 8'd2;
	localparam logic [SCALE_W-1:0]   SCALE_RST   = 16'd11141;
	localparam logic [DIST_W-1:0]    FAR_RST     = 24'd130560;

	localparam logic [1:0] ST_MEASURED = 2'd0;
	localparam logic [1:0] ST_TIMEOUT  = 2'd1;
	localparam logic [1:0] ST_NO_ECHO  = 2'd2;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WAIT = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;

	typedef struct packed {
		logic start_req;
		logic echo_level;
	} item_t;

	typedef struct packed {
		logic              trigger_level;
		logic              done_res;
		logic [1:0]        status;
		logic [DIST_W-1:0] distance_q8;
	} res_t;

	typedef struct packed {
		logic       trig;
		logic       done;
		logic [1:0] status;
	} tick_flags_t;

endpackage

// ===== rtl/uer_tick.sv =====
// Per-tick measurement state: trigger countdown, echo edge detection, tick counter.
module uer_tick #(
	parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  uer_pkg::item_t                 item,
	input  logic [uer_pkg::TIMEOUT_W-1:0]  timeout_ticks,
	input  logic [uer_pkg::TRIG_W-1:0]     trigger_ticks,
	output uer_pkg::tick_flags_t           flags,
	output logic [COUNT_WIDTH-1:0]         count
);
	import uer_pkg::*;

	localparam int CMPW = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;

	logic [1:0]             phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d, count_inc;
	logic [TRIG_W-1:0]      trig_cnt_q, trig_cnt_d, trig_cur;
	logic                   prev_echo_q;
	logic                   rise_q, rise_d;
	logic                   rise, fall, active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			trig_cnt_q  <= '0;
			prev_echo_q <= 1'b0;
			rise_q      <= 1'b0;
		end else if (en) begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			trig_cnt_q  <= trig_cnt_d;
			prev_echo_q <= item.echo_level;
			rise_q      <= rise_d;
		end
	end

	assign rise      = !prev_echo_q && item.echo_level;
	assign fall      = prev_echo_q && !item.echo_level;
	assign active    = (phase_q == PH_WAIT) || (phase_q == PH_HIGH);
	assign count_inc = (count_q != '1) ? count_q + 1'b1 : count_q;
	assign trig_cur  = item.start_req ? trigger_ticks : trig_cnt_q;

	always_comb begin
		phase_d      = phase_q;
		count_d      = count_q;
		rise_d       = rise_q;
		flags.trig   = (trig_cur != '0);
		flags.done   = 1'b0;
		flags.status = ST_MEASURED;
		if (item.start_req) begin
			phase_d = PH_WAIT;
			count_d = '0;
			rise_d  = 1'b0;
		end else if (active) begin
			if (phase_q == PH_WAIT && rise) begin
				count_d = '0;
				rise_d  = 1'b1;
				phase_d = PH_HIGH;
			end else begin
				count_d = count_inc;
				if (phase_q == PH_HIGH && fall) begin
					flags.done = 1'b1;
					phase_d    = PH_IDLE;
				end else if (CMPW'(count_inc) >= CMPW'(timeout_ticks) || count_inc == '1) begin
					flags.done   = 1'b1;
					flags.status = rise_q ? ST_TIMEOUT : ST_NO_ECHO;
					phase_d      = PH_IDLE;
				end
			end
		end
	end

	assign trig_cnt_d = flags.trig ? trig_cur - 1'b1 : '0;
	assign count      = count_d;

endmodule

// ===== rtl/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: config registers, pipeline and distance scaling.
// Each accepted item is one time-base tick and yields exactly one result item. The block
// takes one item per clock unless the result side stalls; on its way to a valid result each
// item passes the input register, the tick-state register and the result register that
// follows the count-times-scale multiplier. Configuration writes are taken in every cycle
// and must only be issued while no item is in flight.
module ultrasonic_echo_ranger #(
	parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  uer_pkg::item_t                item,
	output logic                          res_valid,
	input  logic                          res_ready,
	output uer_pkg::res_t                 res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [uer_pkg::DIST_W-1:0]    cfg_data
);
	import uer_pkg::*;

	localparam int PW = COUNT_WIDTH + SCALE_W;
	localparam int SW = PW - 8;

	logic [TIMEOUT_W-1:0]   timeout_q;
	logic [TRIG_W-1:0]      trigger_q;
	logic [SCALE_W-1:0]     scale_q;
	logic [DIST_W-1:0]      far_q;

	logic                   v_s1, v_s2, res_valid_q;
	item_t                  item_s1;
	tick_flags_t            flags_s2, flags;
	logic [COUNT_WIDTH-1:0] count_s2, count;
	res_t                   res_q, res_d;
	logic                   en_o, en2, en1;
	logic [PW-1:0]          prod;
	logic [SW-1:0]          shifted;
	logic [DIST_W-1:0]      dist_meas;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			trigger_q <= TRIGGER_RST;
			scale_q   <= SCALE_RST;
			far_q     <= FAR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TIMEOUT: timeout_q <= cfg_data[TIMEOUT_W-1:0];
				CFG_TRIGGER: trigger_q <= cfg_data[TRIG_W-1:0];
				CFG_SCALE:   scale_q   <= cfg_data[SCALE_W-1:0];
				CFG_FAR:     far_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en_o       = !res_valid_q || res_ready;
	assign en2        = !v_s2 || en_o;
	assign en1        = !v_s1 || en2;
	assign item_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= item_valid;
			if (en2) v_s2 <= v_s1;
			if (en_o) res_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && en1) item_s1 <= item;
		if (v_s1 && en2) begin
			flags_s2 <= flags;
			count_s2 <= count;
		end
		if (v_s2 && en_o) res_q <= res_d;
	end

	uer_tick #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_tick (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (v_s1 && en2),
		.item          (item_s1),
		.timeout_ticks (timeout_q),
		.trigger_ticks (trigger_q),
		.flags         (flags),
		.count         (count)
	);

	assign prod    = PW'(count_s2) * PW'(scale_q);
	assign shifted = prod[PW-1:8];

	generate
		if (SW > DIST_W) begin : g_sat
			assign dist_meas = (|shifted[SW-1:DIST_W]) ? '1 : shifted[DIST_W-1:0];
		end else begin : g_ext
			assign dist_meas = DIST_W'(shifted);
		end
	endgenerate

	always_comb begin
		res_d.trigger_level = flags_s2.trig;
		res_d.done_res      = flags_s2.done;
		res_d.status        = flags_s2.done ? flags_s2.status : ST_MEASURED;
		res_d.distance_q8   = '0;
		if (flags_s2.done) begin
			case (flags_s2.status)
				ST_MEASURED: res_d.distance_q8 = dist_meas;
				ST_TIMEOUT:  res_d.distance_q8 = far_q;
				default:     res_d.distance_q8 = '0;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/uer_checker.sv =====
// Port-level checker for the ultrasonic echo ranger and its bind statement.
module uer_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input uer_pkg::res_t                 res
);
	import uer_pkg::*;

	logic [2:0] pending_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = item_valid && item_ready;
	assign out_xfer = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_xfer) - 3'(out_xfer);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.done_res |-> res.status == ST_MEASURED && res.distance_q8 == '0)
		else $error("fields nonzero without done");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.status == ST_MEASURED || res.status == ST_TIMEOUT
			|| res.status == ST_NO_ECHO)
		else $error("bad status code");

	a_no_echo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_NO_ECHO |-> res.distance_q8 == '0)
		else $error("no-echo result with distance");

	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid |-> pending_q != '0) and (pending_q <= 3'd3))
		else $error("result without item or too many in flight");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);
